// ----- rtl/sbmq_pkg.sv -----
// Shared definitions for the shared-buffer multi-queue block.
// Field widths, default sizes, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbmq_pkg;

    // Payload field widths
    localparam int DATA_W   = 32;
    localparam int QID_W    = 2;
    localparam int STATUS_W = 2;

    // Default sizes
    localparam int DEF_SLOTS  = 16;
    localparam int DEF_QUEUES = 4;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Data returned by a dequeue from an empty queue
    localparam logic signed [DATA_W-1:0] EMPTY_DATA = -32'sd1;

endpackage

`default_nettype wire

// ----- rtl/sbmq_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Used for the link, data and queue pointer tables. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sbmq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/sbmq_ctrl.sv -----
// Sequencer for the shared-buffer multi-queue: clearing pass, free list head,
// read-modify-write of the link, data and queue pointer tables. Uses sbmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbmq_ctrl #(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4,
    parameter int PW     = 5,
    parameter int IW     = 4,
    parameter int QW     = 2
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // command side
    input  wire logic                              start,
    input  wire logic                              op,
    input  wire logic [sbmq_pkg::QID_W-1:0]        queue_id,
    input  wire logic signed [sbmq_pkg::DATA_W-1:0] data_in,
    output logic                                   busy,
    output logic                                   done,
    output logic signed [sbmq_pkg::DATA_W-1:0]     data_out,
    output logic [sbmq_pkg::STATUS_W-1:0]          status,
    // queue pointer table {head, tail}
    output logic                                   q_we,
    output logic [QW-1:0]                          q_waddr,
    output logic [2*PW-1:0]                        q_wdata,
    output logic [QW-1:0]                          q_raddr,
    input  wire logic [2*PW-1:0]                   q_rdata,
    // link table
    output logic                                   l_we,
    output logic [IW-1:0]                          l_waddr,
    output logic [PW-1:0]                          l_wdata,
    output logic [IW-1:0]                          l_raddr,
    input  wire logic [PW-1:0]                     l_rdata,
    // data table
    output logic                                   s_we,
    output logic [IW-1:0]                          s_waddr,
    output logic [sbmq_pkg::DATA_W-1:0]            s_wdata,
    output logic [IW-1:0]                          s_raddr,
    input  wire logic [sbmq_pkg::DATA_W-1:0]       s_rdata
);

    import sbmq_pkg::*;

    localparam int            CLR_N = (SLOTS > QUEUES) ? SLOTS : QUEUES;
    localparam int            CW    = $clog2(CLR_N);
    localparam logic [PW-1:0] NIL   = PW'(SLOTS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ENQ,
        ST_DEQ_A,
        ST_DEQ_B
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            clr_cnt_reg, clr_cnt_next;
    logic [PW-1:0]            free_head_reg, free_head_next;
    logic [QW-1:0]            q_reg, q_next;
    logic [DATA_W-1:0]        data_reg, data_next;
    logic [PW-1:0]            head_reg, head_next;
    logic [PW-1:0]            tail_reg, tail_next;
    logic                     last_reg, last_next;
    logic                     done_reg, done_next;
    logic [DATA_W-1:0]        data_out_reg, data_out_next;
    logic [STATUS_W-1:0]      status_reg, status_next;

    logic                     accept;
    logic [QW-1:0]            qsel;
    logic [PW-1:0]            rd_head;
    logic [PW-1:0]            rd_tail;
    logic                     clr_link;
    logic                     clr_queue;

    // Queue number folded into range
    function automatic logic [QW-1:0] qmod(input logic [QID_W-1:0] v);
        int t;
        t = int'(v);
        for (int i = 0; i < 3; i++)
        begin
            if (t >= QUEUES)
            begin
                t = t - QUEUES;
            end
        end
        return QW'(t);
    endfunction

    assign accept  = start && (state_reg == ST_IDLE);
    assign qsel    = qmod(queue_id);
    assign rd_head = q_rdata[2*PW-1:PW];
    assign rd_tail = q_rdata[PW-1:0];

    assign clr_link  = ({1'b0, clr_cnt_reg} < (CW+1)'(SLOTS));
    assign clr_queue = ({1'b0, clr_cnt_reg} < (CW+1)'(QUEUES));

    // Read addresses: pointers on accept, head slot while the pointers are in
    assign q_raddr = qsel;
    assign s_raddr = rd_head[IW-1:0];
    always_comb
    begin
        if (state_reg == ST_DEQ_A)
        begin
            l_raddr = rd_head[IW-1:0];
        end
        else
        begin
            l_raddr = free_head_reg[IW-1:0];
        end
    end

    // Next state, table writes and results
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        free_head_next = free_head_reg;
        q_next         = q_reg;
        data_next      = data_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        last_next      = last_reg;
        done_next      = 1'b0;
        data_out_next  = data_out_reg;
        status_next    = status_reg;

        q_we    = 1'b0;
        q_waddr = q_reg;
        q_wdata = {NIL, NIL};
        l_we    = 1'b0;
        l_waddr = free_head_reg[IW-1:0];
        l_wdata = NIL;
        s_we    = 1'b0;
        s_waddr = free_head_reg[IW-1:0];
        s_wdata = data_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // link[i] = i + 1 (last entry gets null), pointers null
                l_we    = clr_link;
                l_waddr = clr_cnt_reg[IW-1:0];
                l_wdata = PW'(clr_cnt_reg) + PW'(1);
                q_we    = clr_queue;
                q_waddr = clr_cnt_reg[QW-1:0];
                q_wdata = {NIL, NIL};
                if (clr_cnt_reg == CW'(CLR_N - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CW'(1);
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    q_next    = qsel;
                    data_next = data_in;
                    state_next = (op == OP_DEQ) ? ST_DEQ_A : ST_ENQ;
                end
            end

            ST_ENQ:
            begin
                done_next     = 1'b1;
                data_out_next = '0;
                state_next    = ST_IDLE;
                if (free_head_reg == NIL)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    status_next    = STATUS_OK;
                    free_head_next = l_rdata;
                    s_we           = 1'b1;
                    q_we           = 1'b1;
                    if (rd_head == NIL)
                    begin
                        q_wdata = {free_head_reg, free_head_reg};
                    end
                    else
                    begin
                        // append after the current tail
                        q_wdata = {rd_head, free_head_reg};
                        l_we    = 1'b1;
                        l_waddr = rd_tail[IW-1:0];
                        l_wdata = free_head_reg;
                    end
                end
            end

            ST_DEQ_A:
            begin
                if (rd_head == NIL)
                begin
                    done_next     = 1'b1;
                    data_out_next = EMPTY_DATA;
                    status_next   = STATUS_EMPTY;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    head_next  = rd_head;
                    tail_next  = rd_tail;
                    last_next  = (rd_head == rd_tail);
                    state_next = ST_DEQ_B;
                end
            end

            ST_DEQ_B:
            begin
                // unlink head, push its slot onto the free list
                q_we           = 1'b1;
                q_wdata        = {(last_reg ? NIL : l_rdata), tail_reg};
                l_we           = 1'b1;
                l_waddr        = head_reg[IW-1:0];
                l_wdata        = free_head_reg;
                free_head_next = head_reg;
                done_next      = 1'b1;
                data_out_next  = s_rdata;
                status_next    = STATUS_OK;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            free_head_reg <= '0;
            q_reg         <= '0;
            data_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            last_reg      <= 1'b0;
            done_reg      <= 1'b0;
            data_out_reg  <= '0;
            status_reg    <= STATUS_OK;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            free_head_reg <= free_head_next;
            q_reg         <= q_next;
            data_reg      <= data_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            last_reg      <= last_next;
            done_reg      <= done_next;
            data_out_reg  <= data_out_next;
            status_reg    <= status_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign data_out = data_out_reg;
    assign status   = status_reg;

endmodule

`default_nettype wire

// ----- rtl/shared_buffer_multi_queue_top.sv -----
// Top level of the shared-buffer multi-queue: sequencer plus link, data and
// queue pointer RAMs. Depends on sbmq_pkg, sbmq_ram and sbmq_ctrl.
//
//   Channel   Signals                          Transfer when
//   command   start, op, queue_id, data_in     start high and busy low
//   result    done, data_out, status           done high (one cycle)
//
// An enqueue passes through ST_ENQ before the next accept; a dequeue through
// ST_DEQ_A and ST_DEQ_B (only ST_DEQ_A when the queue is empty): the dequeue
// reads the queue pointers, then the link and data entries of the head slot,
// each a synchronous RAM read. A clearing pass over max(SLOTS, QUEUES) entries
// after reset initializes link and pointer tables; busy stays high meanwhile.
// Each result is shown for one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

module shared_buffer_multi_queue_top #(
    parameter int SLOTS  = sbmq_pkg::DEF_SLOTS,
    parameter int QUEUES = sbmq_pkg::DEF_QUEUES
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic                               op,
    input  wire logic [sbmq_pkg::QID_W-1:0]         queue_id,
    input  wire logic signed [sbmq_pkg::DATA_W-1:0] data_in,
    output logic                                    busy,
    output logic                                    done,
    output logic signed [sbmq_pkg::DATA_W-1:0]      data_out,
    output logic [sbmq_pkg::STATUS_W-1:0]           status
);

    import sbmq_pkg::*;

    localparam int PW = $clog2(SLOTS + 1);
    localparam int IW = $clog2(SLOTS);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    logic              q_we;
    logic [QW-1:0]     q_waddr;
    logic [2*PW-1:0]   q_wdata;
    logic [QW-1:0]     q_raddr;
    logic [2*PW-1:0]   q_rdata;
    logic              l_we;
    logic [IW-1:0]     l_waddr;
    logic [PW-1:0]     l_wdata;
    logic [IW-1:0]     l_raddr;
    logic [PW-1:0]     l_rdata;
    logic              s_we;
    logic [IW-1:0]     s_waddr;
    logic [DATA_W-1:0] s_wdata;
    logic [IW-1:0]     s_raddr;
    logic [DATA_W-1:0] s_rdata;

    // Sequencer
    sbmq_ctrl #(
        .SLOTS  (SLOTS),
        .QUEUES (QUEUES),
        .PW     (PW),
        .IW     (IW),
        .QW     (QW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .op       (op),
        .queue_id (queue_id),
        .data_in  (data_in),
        .busy     (busy),
        .done     (done),
        .data_out (data_out),
        .status   (status),
        .q_we     (q_we),
        .q_waddr  (q_waddr),
        .q_wdata  (q_wdata),
        .q_raddr  (q_raddr),
        .q_rdata  (q_rdata),
        .l_we     (l_we),
        .l_waddr  (l_waddr),
        .l_wdata  (l_wdata),
        .l_raddr  (l_raddr),
        .l_rdata  (l_rdata),
        .s_we     (s_we),
        .s_waddr  (s_waddr),
        .s_wdata  (s_wdata),
        .s_raddr  (s_raddr),
        .s_rdata  (s_rdata)
    );

    // Queue head/tail pointers
    sbmq_ram #(
        .DEPTH (QUEUES),
        .WIDTH (2 * PW),
        .AW    (QW)
    ) u_qptr_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // Next-slot links (queues and free list)
    sbmq_ram #(
        .DEPTH (SLOTS),
        .WIDTH (PW),
        .AW    (IW)
    ) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    // Data words
    sbmq_ram #(
        .DEPTH (SLOTS),
        .WIDTH (DATA_W),
        .AW    (IW)
    ) u_data_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for shared_buffer_multi_queue_top: directed and random
// enqueue/dequeue commands checked against an in-bench linked-list model.
// Depends on sbmq_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb;
    import sbmq_pkg::*;

    localparam int SLOTS   = DEF_SLOTS;
    localparam int QUEUES  = DEF_QUEUES;
    localparam int NIL     = SLOTS;
    localparam int ITEMS   = 1050;
    localparam int PHASES  = 4;
    localparam int MAX_GAP = 20;

    typedef logic [4:0] slot_t;

    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic [STATUS_W-1:0]      status;
    } cmd_result_t;

    // Linked-list model of the shared store plus the queue of pending results
    class multi_queue_model;
        slot_t                    q_head[QUEUES];
        slot_t                    q_tail[QUEUES];
        slot_t                    next_slot[SLOTS];
        logic signed [DATA_W-1:0] slot_word[SLOTS];
        slot_t                    free_top;
        cmd_result_t              pending_results[$];
        int                       mismatch_count;

        function new();
            for (int i = 0; i < QUEUES; i++)
            begin
                q_head[i] = slot_t'(NIL);
                q_tail[i] = slot_t'(NIL);
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                next_slot[i] = slot_t'(i + 1);
                slot_word[i] = '0;
            end
            next_slot[SLOTS-1] = slot_t'(NIL);
            free_top           = '0;
            mismatch_count     = 0;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            mismatch_count++;
        endtask

        // Apply one accepted command and queue the result it should produce
        function void note_cmd(logic o, logic [QID_W-1:0] q, logic signed [DATA_W-1:0] d);
            cmd_result_t r;
            slot_t       s;
            int          qi;
            qi       = int'(q) % QUEUES;
            r.data   = '0;
            r.status = STATUS_OK;
            if (o == OP_ENQ)
            begin
                s = free_top;
                if (s >= NIL)
                    r.status = STATUS_FULL;
                else
                begin
                    free_top = next_slot[s];
                    // empty queue: head and (stale) tail both get replaced
                    if (q_head[qi] >= NIL)
                        q_head[qi] = s;
                    else if (q_tail[qi] < NIL)
                        next_slot[q_tail[qi]] = s;
                    next_slot[s] = slot_t'(NIL);
                    q_tail[qi]   = s;
                    slot_word[s] = d;
                end
            end
            else
            begin
                s = q_head[qi];
                if (s >= NIL)
                begin
                    r.data   = EMPTY_DATA;
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    q_head[qi]   = next_slot[s];
                    next_slot[s] = free_top;
                    free_top     = s;
                    r.data       = slot_word[s];
                end
            end
            pending_results.push_back(r);
        endfunction

        task check_result(logic signed [DATA_W-1:0] d, logic [STATUS_W-1:0] st);
            cmd_result_t r;
            if (pending_results.size() == 0)
                report($sformatf("result with nothing pending: data_out=%0d status=%0d", d, st));
            else
            begin
                r = pending_results.pop_front();
                if (d !== r.data)
                    report($sformatf("data_out %0d, want %0d", d, r.data));
                if (st !== r.status)
                    report($sformatf("status %0d, want %0d", st, r.status));
            end
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     op;
    logic [QID_W-1:0]         queue_id;
    logic signed [DATA_W-1:0] data_in;
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] data_out;
    logic [STATUS_W-1:0]      status;

    multi_queue_model model = new();

    shared_buffer_multi_queue_top #(
        .SLOTS  (SLOTS),
        .QUEUES (QUEUES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .op       (op),
        .queue_id (queue_id),
        .data_in  (data_in),
        .busy     (busy),
        .done     (done),
        .data_out (data_out),
        .status   (status)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Result monitor: every strobed cycle is one transfer
    always @(posedge clk)
    begin
        if (rst_n && done)
            model.check_result(data_out, status);
    end

    // Count of idle cycles before a command; geometric in pct percent
    function automatic int pick_gap(int pct);
        int g;
        g = 0;
        while (g < MAX_GAP && $urandom_range(99) < pct)
            g++;
        return g;
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Present one command and hold it until the transfer; leaves start high
    task send_cmd(logic o, logic [QID_W-1:0] q, logic [DATA_W-1:0] d, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        op       <= o;
        queue_id <= q;
        data_in  <= d;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        model.note_cmd(o, q, d);
    endtask

    task run_directed();
        // dequeue from empty queues
        send_cmd(OP_DEQ, 2'd0, 32'h0, 0);
        send_cmd(OP_DEQ, 2'd3, 32'hFFFF_FFFF, 0);
        // data extremes, one per queue
        send_cmd(OP_ENQ, 2'd0, 32'h7FFF_FFFF, 0);
        send_cmd(OP_ENQ, 2'd1, 32'h8000_0000, 0);
        send_cmd(OP_ENQ, 2'd2, 32'h0000_0000, 0);
        send_cmd(OP_ENQ, 2'd3, 32'hFFFF_FFFF, 0);
        // empty q0 then enqueue again past its stale tail
        send_cmd(OP_DEQ, 2'd0, 32'h0, 0);
        send_cmd(OP_ENQ, 2'd0, 32'h1234_5678, 0);
        // fill the remaining slots, then one more for store full
        for (int i = 0; i < SLOTS - 4; i++)
            send_cmd(OP_ENQ, QID_W'(i), (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555, 0);
        send_cmd(OP_ENQ, 2'd1, 32'hDEAD_BEEF, 0);
        send_cmd(OP_DEQ, 2'd1, 32'h0, 0);
        send_cmd(OP_DEQ, 2'd3, 32'h0, 0);
    endtask

    // Random traffic; enqueue bias switches so the store swings between full and empty
    task run_random(int count, int idle_pct);
        int enq_pct;
        enq_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 32 == 0)
            begin
                case ($urandom_range(2))
                    0:       enq_pct = 80;
                    1:       enq_pct = 20;
                    default: enq_pct = 50;
                endcase
            end
            send_cmd(($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ,
                     QID_W'($urandom_range(QUEUES - 1)), pick_word(), pick_gap(idle_pct));
        end
    endtask

    // Main sequence
    initial
    begin
        int idle_pct[PHASES];
        idle_pct = '{0, 51, 0, 14};
        rst_n    <= 1'b0;
        start    <= 1'b0;
        op       <= OP_ENQ;
        queue_id <= '0;
        data_in  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int p = 0; p < PHASES; p++)
            run_random(ITEMS / PHASES, idle_pct[p]);
        start <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        while (model.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (model.pending_results.size() != 0)
            model.report("results still outstanding at end of run");
        if (model.mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
